[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by pffrs_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pff assertion failed");

// next-cycle implication, disabled in reset
`define PFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pff assertion failed");

`endif

[rtl/pffrs_pkg.sv]
// ----------------------------------------------------------------------------
// pffrs_pkg
// shared types and constants of the page fault frequency resident set
// ----------------------------------------------------------------------------
package pffrs_pkg;

    localparam int PAGE_W    = 6;
    localparam int WIN_W     = 16;
    localparam int CNT_OUT_W = 7;
    localparam int CHUNK_W   = 8;
    localparam int CHUNK_LG  = 3;
    localparam logic [WIN_W-1:0] WIN_RESET = 16'd4;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SWEEP = 2'b10
    } t_state;

    typedef struct packed {
        logic accept;
        logic sweep;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_sweep;
        logic last_chunk;
    } t_status;

endpackage

[rtl/pffrs_if.sv]
// ----------------------------------------------------------------------------
// pffrs_if
// valid/ready channels for page references and results
// ----------------------------------------------------------------------------
interface pffrs_in_if;
    logic                          valid;
    logic                          ready;
    logic [pffrs_pkg::PAGE_W-1:0]  page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface pffrs_out_if;
    logic                            valid;
    logic                            ready;
    logic                            fault;
    logic [pffrs_pkg::CNT_OUT_W-1:0] evicted_count;
    logic [pffrs_pkg::CNT_OUT_W-1:0] resident_count;
    logic                            overflow;

    modport source (output valid, output fault, output evicted_count,
                    output resident_count, output overflow, input ready);
    modport sink   (input valid, input fault, input evicted_count,
                    input resident_count, input overflow, output ready);
endinterface

[rtl/pffrs_ctrl.sv]
// ----------------------------------------------------------------------------
// pffrs_ctrl
// controller: accepts words, runs the eviction sweep, owns result valid
// ----------------------------------------------------------------------------
module pffrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  pffrs_pkg::t_status  i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output pffrs_pkg::t_cmd     o_cmd
);

    pffrs_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready = (r_state == pffrs_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept = accept;
        o_cmd.sweep  = (r_state == pffrs_pkg::S_SWEEP);
        o_cmd.load   = (accept && !i_status.need_sweep) ||
                       ((r_state == pffrs_pkg::S_SWEEP) && i_status.last_chunk);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pffrs_pkg::S_IDLE: begin
                if (accept && i_status.need_sweep) begin
                    n_state = pffrs_pkg::S_SWEEP;
                end
            end
            pffrs_pkg::S_SWEEP: begin
                if (i_status.last_chunk) begin
                    n_state = pffrs_pkg::S_IDLE;
                end
            end
            default: n_state = pffrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pffrs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/pffrs_dp.sv]
// ----------------------------------------------------------------------------
// pffrs_dp
// datapath: resident and referenced bitmaps, counters, chunked eviction
// ----------------------------------------------------------------------------
module pffrs_dp #(
    parameter int NUM_PAGES = 64,
    parameter int DIST_BITS = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pffrs_pkg::t_cmd                   i_cmd,
    input  logic [pffrs_pkg::PAGE_W-1:0]      i_page,
    input  logic                              i_cfg_we,
    input  logic [pffrs_pkg::WIN_W-1:0]       i_cfg_wdata,
    output pffrs_pkg::t_status                o_status,
    output logic                              o_fault,
    output logic [pffrs_pkg::CNT_OUT_W-1:0]   o_evicted_count,
    output logic [pffrs_pkg::CNT_OUT_W-1:0]   o_resident_count,
    output logic                              o_overflow
);

    localparam int NCH   = (NUM_PAGES + pffrs_pkg::CHUNK_W - 1) / pffrs_pkg::CHUNK_W;
    localparam int CHK_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W = CHK_W + pffrs_pkg::CHUNK_LG;
    localparam int EXT_W = (IDX_W > pffrs_pkg::PAGE_W) ? IDX_W : pffrs_pkg::PAGE_W;
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int OUT_X = (CNT_W > pffrs_pkg::CNT_OUT_W) ? CNT_W : pffrs_pkg::CNT_OUT_W;
    localparam int SW    = (DIST_BITS > pffrs_pkg::WIN_W) ? DIST_BITS : pffrs_pkg::WIN_W;
    localparam int POP_W = pffrs_pkg::CHUNK_LG + 1;

    typedef logic [NCH-1:0][pffrs_pkg::CHUNK_W-1:0] t_map;

    t_map                          r_res, n_res;
    t_map                          r_ref, n_ref;
    logic [CNT_W-1:0]              r_total, n_total;
    logic [DIST_BITS-1:0]          r_since, n_since;
    logic [pffrs_pkg::WIN_W-1:0]   r_window;
    logic [CHK_W-1:0]              r_chunk, n_chunk;
    logic [IDX_W-1:0]              r_page, n_page;
    logic [CNT_W-1:0]              r_evict, n_evict;
    logic                          r_o_fault, r_o_ovf;
    logic [CNT_W-1:0]              r_o_evict, r_o_total;

    logic [EXT_W-1:0]              page_ext;
    logic [IDX_W-1:0]              idx;
    logic                          in_range;
    logic                          hit;
    logic                          last;
    logic [pffrs_pkg::CHUNK_W-1:0] ev;
    logic [POP_W-1:0]              pop;
    logic [CNT_W-1:0]              sum;
    logic [OUT_X-1:0]              ev_x, tot_x;

    assign page_ext = EXT_W'(i_page);
    assign idx      = page_ext[IDX_W-1:0];
    assign in_range = (32'(i_page) < 32'(NUM_PAGES));
    assign hit      = in_range &&
                      r_res[idx[IDX_W-1:pffrs_pkg::CHUNK_LG]][idx[pffrs_pkg::CHUNK_LG-1:0]];
    assign last     = (r_chunk == CHK_W'(NCH - 1));

    assign o_status.need_sweep = in_range && !hit && (SW'(r_since) > SW'(r_window));
    assign o_status.last_chunk = last;

    // unreferenced residents in the current chunk
    always_comb begin
        ev  = r_res[r_chunk] & ~r_ref[r_chunk];
        pop = '0;
        for (int b = 0; b < pffrs_pkg::CHUNK_W; b++) begin
            pop = pop + POP_W'(ev[b]);
        end
        sum = r_evict + CNT_W'(pop);
    end

    always_comb begin
        n_res   = r_res;
        n_ref   = r_ref;
        n_total = r_total;
        n_since = r_since;
        n_chunk = r_chunk;
        n_page  = r_page;
        n_evict = r_evict;
        if (i_cmd.accept) begin
            n_page  = idx;
            n_chunk = '0;
            n_evict = '0;
            if (in_range) begin
                if (hit) begin
                    n_ref[idx[IDX_W-1:pffrs_pkg::CHUNK_LG]][idx[pffrs_pkg::CHUNK_LG-1:0]] = 1'b1;
                    if (r_since != '1) begin
                        n_since = r_since + 1'b1;
                    end
                end else if (!o_status.need_sweep) begin
                    n_ref = '0;
                    n_res[idx[IDX_W-1:pffrs_pkg::CHUNK_LG]][idx[pffrs_pkg::CHUNK_LG-1:0]] = 1'b1;
                    n_total = r_total + 1'b1;
                    n_since = DIST_BITS'(1);
                end
            end
        end
        if (i_cmd.sweep) begin
            n_res[r_chunk] = r_res[r_chunk] & r_ref[r_chunk];
            n_evict        = sum;
            n_chunk        = r_chunk + 1'b1;
            if (last) begin
                n_ref = '0;
                n_res[r_page[IDX_W-1:pffrs_pkg::CHUNK_LG]][r_page[pffrs_pkg::CHUNK_LG-1:0]] = 1'b1;
                n_total = r_total - sum + 1'b1;
                n_since = DIST_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= '0;
            r_ref    <= '0;
            r_total  <= '0;
            r_since  <= DIST_BITS'(1);
            r_window <= pffrs_pkg::WIN_RESET;
            r_chunk  <= '0;
        end else begin
            r_res   <= n_res;
            r_ref   <= n_ref;
            r_total <= n_total;
            r_since <= n_since;
            r_chunk <= n_chunk;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_evict <= n_evict;
        if (i_cmd.load) begin
            r_o_fault <= i_cmd.sweep || !hit;
            r_o_ovf   <= i_cmd.accept && !in_range;
            r_o_evict <= i_cmd.sweep ? sum : '0;
            r_o_total <= n_total;
        end
    end

    assign ev_x  = OUT_X'(r_o_evict);
    assign tot_x = OUT_X'(r_o_total);

    assign o_fault          = r_o_fault;
    assign o_overflow       = r_o_ovf;
    assign o_evicted_count  = ev_x[pffrs_pkg::CNT_OUT_W-1:0];
    assign o_resident_count = tot_x[pffrs_pkg::CNT_OUT_W-1:0];

endmodule

[rtl/page_fault_frequency_resident_set.sv]
// ----------------------------------------------------------------------------
// page_fault_frequency_resident_set
// resident page set kept under the page fault frequency policy
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    page_number
//   o_result  out   valid/ready    fault, evicted_count, resident_count, overflow
//   cfg       in    i_cfg_we       i_cfg_wdata (window_limit)
//
// hits, pages beyond the store and faults inside the window are answered without a sweep
// a fault past the window sweeps the bitmaps, 8 pages a cycle
// one result register; a new word is taken while the held result drains
// reset is synchronous and empties the set, window_limit returns to 4
// ----------------------------------------------------------------------------
module page_fault_frequency_resident_set #(
    parameter int NUM_PAGES = 64,
    parameter int DIST_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pffrs_in_if.sink                      i_item,
    pffrs_out_if.source                   o_result,
    input  logic                          i_cfg_we,
    input  logic [pffrs_pkg::WIN_W-1:0]   i_cfg_wdata
);

    pffrs_pkg::t_cmd    cmd;
    pffrs_pkg::t_status status;
    logic               in_ready;
    logic               out_valid;

    pffrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    pffrs_dp #(
        .NUM_PAGES (NUM_PAGES),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_page           (i_item.page_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_status         (status),
        .o_fault          (o_result.fault),
        .o_evicted_count  (o_result.evicted_count),
        .o_resident_count (o_result.resident_count),
        .o_overflow       (o_result.overflow)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule

[rtl/pffrs_checker.sv]
// ----------------------------------------------------------------------------
// pffrs_checker
// port-level checks of the resident set block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pffrs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_fault,
    input logic [pffrs_pkg::CNT_OUT_W-1:0]   i_evicted_count,
    input logic [pffrs_pkg::CNT_OUT_W-1:0]   i_resident_count,
    input logic                              i_overflow
);

    // held result stays put until taken
    `PFF_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_fault) && $stable(i_evicted_count) && $stable(i_resident_count) && $stable(i_overflow))

    // a word is only taken when the result slot is free or draining
    `PFF_ASSERT_IMP(a_slot, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid || i_out_ready)

    // a hit never evicts and never overflows
    `PFF_ASSERT_IMP(a_hit, i_clk, i_rst_n, i_out_valid && !i_fault, i_evicted_count == '0 && !i_overflow)

    // overflow is a fault with nothing evicted
    `PFF_ASSERT_IMP(a_ovf, i_clk, i_rst_n, i_out_valid && i_overflow, i_fault && i_evicted_count == '0)

    // no result right after reset
    `PFF_ASSERT_IMP(a_rst, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind page_fault_frequency_resident_set pffrs_checker u_pffrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_fault          (o_result.fault),
    .i_evicted_count  (o_result.evicted_count),
    .i_resident_count (o_result.resident_count),
    .i_overflow       (o_result.overflow)
);
